@@ hw/rtl/udp_dv_pkg.sv @@
// Shared types, status codes and checksum fold function for the UDP datagram validator.
`default_nettype none
package udp_dv_pkg;

  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MAX_SMALL = 3'd1;
  localparam logic [2:0] ST_OVER_MAX  = 3'd2;
  localparam logic [2:0] ST_OVER_IP   = 3'd3;
  localparam logic [2:0] ST_UNDER_HDR = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;

  localparam logic REQ_HEADER  = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        fail;
    logic [2:0]  status;
    logic [19:0] seed_sum;
    logic [15:0] bytes_left;
    logic [15:0] expected_sum;
  } hdr_res_t;

  // fold a 32-bit one's-complement sum twice and complement it
  function automatic logic [15:0] fold_sum(input logic [31:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    u = {1'b0, t[15:0]} + {16'b0, t[16]};
    return ~u[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/udp_dv_hdr_check.sv @@
// Header size checks and pseudo-header seed sum.
`default_nettype none
module udp_dv_hdr_check (
  input  wire logic [15:0]         max_packet_len,
  input  wire logic [31:0]         src_addr,
  input  wire logic [31:0]         dst_addr,
  input  wire logic [7:0]          protocol,
  input  wire logic [15:0]         ip_total_len,
  input  wire logic [3:0]          ip_hdr_words,
  input  wire logic [15:0]         src_port,
  input  wire logic [15:0]         dst_port,
  input  wire logic [15:0]         udp_len,
  input  wire logic [15:0]         udp_sum,
  output udp_dv_pkg::hdr_res_t     hdr_res
);

  logic [15:0] ihl_bytes;
  logic [15:0] ip_payload;
  logic        ip_neg;
  logic [19:0] seed;

  assign ihl_bytes  = {10'b0, ip_hdr_words, 2'b00};
  assign ip_neg     = ip_total_len < ihl_bytes;
  assign ip_payload = ip_total_len - ihl_bytes;

  assign seed = {4'b0, src_addr[31:16]} + {4'b0, src_addr[15:0]}
              + {4'b0, dst_addr[31:16]} + {4'b0, dst_addr[15:0]}
              + {12'b0, protocol} + {4'b0, ip_payload}
              + {4'b0, src_port} + {4'b0, dst_port} + {4'b0, udp_len};

  always_comb begin
    hdr_res.fail         = 1'b1;
    hdr_res.status       = udp_dv_pkg::ST_OK;
    hdr_res.seed_sum     = seed;
    hdr_res.bytes_left   = udp_len - udp_dv_pkg::UDP_HDR_BYTES;
    hdr_res.expected_sum = udp_sum;
    if (max_packet_len < udp_dv_pkg::UDP_HDR_BYTES) begin
      hdr_res.status = udp_dv_pkg::ST_MAX_SMALL;
    end else if (udp_len > max_packet_len) begin
      hdr_res.status = udp_dv_pkg::ST_OVER_MAX;
    end else if (ip_neg || (udp_len > ip_payload)) begin
      hdr_res.status = udp_dv_pkg::ST_OVER_IP;
    end else if (udp_len < udp_dv_pkg::UDP_HDR_BYTES) begin
      hdr_res.status = udp_dv_pkg::ST_UNDER_HDR;
    end else begin
      hdr_res.fail = 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/udp_dv_accum.sv @@
// Running checksum state, finalize and compare, and the result register.
`default_nettype none
module udp_dv_accum (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 req_type,
  input  wire logic [7:0]           data_byte,
  input  wire udp_dv_pkg::hdr_res_t hdr_res,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      out_valid_res,
  output logic [15:0]               out_computed_sum,
  output logic [2:0]                out_status
);

  logic [31:0] sum_r,   sum_nxt;
  logic [15:0] left_r,  left_nxt;
  logic        odd_r,   odd_nxt;
  logic        open_r,  open_nxt;
  logic [15:0] exp_r,   exp_nxt;

  logic        emit;
  logic        res_valid;
  logic [15:0] res_sum;
  logic [2:0]  res_status;
  logic        fin;
  logic [15:0] folded;

  logic        out_valid_r;
  logic        out_valid_res_r;
  logic [15:0] out_sum_r;
  logic [2:0]  out_status_r;

  always_comb begin
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    odd_nxt    = odd_r;
    open_nxt   = open_r;
    exp_nxt    = exp_r;
    fin        = 1'b0;
    emit       = 1'b0;
    res_valid  = 1'b0;
    res_sum    = 16'd0;
    res_status = udp_dv_pkg::ST_OK;
    folded     = 16'd0;
    if (req_type == udp_dv_pkg::REQ_HEADER) begin
      open_nxt = 1'b0;
      if (hdr_res.fail) begin
        emit       = 1'b1;
        res_status = hdr_res.status;
      end else begin
        sum_nxt  = {12'b0, hdr_res.seed_sum};
        exp_nxt  = hdr_res.expected_sum;
        odd_nxt  = 1'b0;
        left_nxt = hdr_res.bytes_left;
        open_nxt = 1'b1;
        fin      = (hdr_res.bytes_left == 16'd0);
      end
    end else if (open_r) begin
      if (odd_r) begin
        sum_nxt = sum_r + {24'b0, data_byte};
      end else begin
        sum_nxt = sum_r + {16'b0, data_byte, 8'b0};
      end
      odd_nxt  = ~odd_r;
      left_nxt = left_r - 16'd1;
      fin      = (left_nxt == 16'd0);
    end
    if (fin) begin
      folded    = udp_dv_pkg::fold_sum(sum_nxt);
      open_nxt  = 1'b0;
      emit      = 1'b1;
      res_sum   = folded;
      res_valid = (folded == exp_nxt);
      res_status = res_valid ? udp_dv_pkg::ST_OK : udp_dv_pkg::ST_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 32'd0;
      left_r      <= 16'd0;
      odd_r       <= 1'b0;
      open_r      <= 1'b0;
      exp_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        sum_r       <= sum_nxt;
        left_r      <= left_nxt;
        odd_r       <= odd_nxt;
        open_r      <= open_nxt;
        exp_r       <= exp_nxt;
        out_valid_r <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_valid_res_r <= res_valid;
      out_sum_r       <= res_sum;
      out_status_r    <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = out_valid_res_r;
  assign out_computed_sum = out_sum_r;
  assign out_status       = out_status_r;

endmodule
`default_nettype wire

@@ hw/rtl/udp_datagram_validate.sv @@
// Top level of the UDP datagram validator: request register, checks and accumulator.
`default_nettype none
// Takes one request per cycle while in_stall is low: a header request opens a
// datagram and carries the IPv4 pseudo-header and UDP header, then udp_len - 8
// payload requests follow, one byte each. The request that causes a result (the
// header on a size failure or an empty payload, otherwise the last payload byte)
// passes through a request register, and the result is held in a result register;
// while a result waits under out_stall, one more request can enter and then waits.
// A header arriving mid-datagram abandons the open one silently; stray payload
// bytes with no open datagram produce nothing. cfg_wr_data is written to
// max_packet_len (reset 65535) whenever cfg_wr_en is high and should change only
// while idle.
module udp_datagram_validate (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [7:0]  in_protocol,
  input  wire logic [15:0] in_ip_total_len,
  input  wire logic [3:0]  in_ip_hdr_words,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [15:0] in_udp_len,
  input  wire logic [15:0] in_udp_sum,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_valid_res,
  output logic [15:0]      out_computed_sum,
  output logic [2:0]       out_status
);

  logic [15:0] max_len_r;
  logic        req_v_r;
  logic        req_type_r;
  logic [31:0] src_addr_r;
  logic [31:0] dst_addr_r;
  logic [7:0]  protocol_r;
  logic [15:0] ip_total_len_r;
  logic [3:0]  ip_hdr_words_r;
  logic [15:0] src_port_r;
  logic [15:0] dst_port_r;
  logic [15:0] udp_len_r;
  logic [15:0] udp_sum_r;
  logic [7:0]  data_byte_r;

  logic                  adv;
  logic                  in_take;
  udp_dv_pkg::hdr_res_t  hdr_res;

  assign adv      = req_v_r && (!out_valid || !out_stall);
  assign in_stall = req_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 16'hffff;
      req_v_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (in_take) begin
        req_v_r <= 1'b1;
      end else if (adv) begin
        req_v_r <= 1'b0;
      end
    end
  end

  // hold the request payload until it advances
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_type_r     <= in_req_type;
      src_addr_r     <= in_src_addr;
      dst_addr_r     <= in_dst_addr;
      protocol_r     <= in_protocol;
      ip_total_len_r <= in_ip_total_len;
      ip_hdr_words_r <= in_ip_hdr_words;
      src_port_r     <= in_src_port;
      dst_port_r     <= in_dst_port;
      udp_len_r      <= in_udp_len;
      udp_sum_r      <= in_udp_sum;
      data_byte_r    <= in_data_byte;
    end
  end

  udp_dv_hdr_check u_hdr_check (
    .max_packet_len (max_len_r),
    .src_addr       (src_addr_r),
    .dst_addr       (dst_addr_r),
    .protocol       (protocol_r),
    .ip_total_len   (ip_total_len_r),
    .ip_hdr_words   (ip_hdr_words_r),
    .src_port       (src_port_r),
    .dst_port       (dst_port_r),
    .udp_len        (udp_len_r),
    .udp_sum        (udp_sum_r),
    .hdr_res        (hdr_res)
  );

  udp_dv_accum u_accum (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .req_type         (req_type_r),
    .data_byte        (data_byte_r),
    .hdr_res          (hdr_res),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_valid_res    (out_valid_res),
    .out_computed_sum (out_computed_sum),
    .out_status       (out_status)
  );

  a_pass_iff_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_status == udp_dv_pkg::ST_OK)))
    else $error("pass flag disagrees with status");

  a_size_fail_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != udp_dv_pkg::ST_OK
       && out_status != udp_dv_pkg::ST_MISMATCH) |-> (out_computed_sum == 16'd0))
    else $error("size failure with nonzero checksum");

  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(req_v_r))
    else $error("result without a request");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (req_v_r && !in_stall && !in_take) |=> !req_v_r)
    else $error("request register not drained");

endmodule
`default_nettype wire
